/* sv/trb_pkg.sv */
// ----------------------------------------------------------------------------
// trb_pkg
// Shared widths, reset values, register codes and pipeline control types for
// the triangle transform and bounding box unit.
// ----------------------------------------------------------------------------
package trb_pkg;

    // Field widths
    localparam int COORD_BITS_DEF = 12;
    localparam int SCALE_W        = 16;
    localparam int TRIG_W         = 16;
    localparam int SHIFT_W        = 13;
    localparam int OUT_W          = 21;
    localparam int BOX_W          = 22;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 1;

    // Fixed point fraction bits: scale Q8.8, sine/cosine Q1.14
    localparam int SCALE_FRAC = 8;
    localparam int TRIG_FRAC  = 14;

    localparam int NUM_VTX    = 3;
    localparam int NUM_STAGES = 6;

    // Screen size after reset
    localparam logic [CFG_W-1:0] SCREEN_W_RST = 13'd640;
    localparam logic [CFG_W-1:0] SCREEN_H_RST = 13'd480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    // Stage load strobes for the vertex transform stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } xf_load_t;

    // Stage load strobes for the bounding box stages
    typedef struct packed {
        logic s5;
        logic s6;
    } box_load_t;

endpackage

/* sv/triangle_transform_bbox_unit.sv */
// Throughput: one triangle per cycle while not stalled; six register stages,
// valid bits travel with the data and each stage holds only while the one
// after it is full and stalled, so bubbles close up under back pressure.
// Reset: rst_n clears all valid bits and sets the screen to 640 x 480.
// ----------------------------------------------------------------------------
// triangle_transform_bbox_unit
// Scales, rotates and translates one triangle per request and returns the
// screen coordinates, the bounding box and an on-screen flag.
// ----------------------------------------------------------------------------
module triangle_transform_bbox_unit #(
    parameter int COORD_BITS = trb_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [trb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [trb_pkg::CFG_W-1:0]              cfg_data,
    // request channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COORD_BITS-1:0]           ax,
    input  logic signed [COORD_BITS-1:0]           ay,
    input  logic signed [COORD_BITS-1:0]           bxin,
    input  logic signed [COORD_BITS-1:0]           byin,
    input  logic signed [COORD_BITS-1:0]           cx,
    input  logic signed [COORD_BITS-1:0]           cy,
    input  logic        [trb_pkg::SCALE_W-1:0]     scale_factor,
    input  logic signed [trb_pkg::TRIG_W-1:0]      cos_rot,
    input  logic signed [trb_pkg::TRIG_W-1:0]      sin_rot,
    input  logic signed [trb_pkg::SHIFT_W-1:0]     shift_x,
    input  logic signed [trb_pkg::SHIFT_W-1:0]     shift_y,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [trb_pkg::OUT_W-1:0]       out_ax,
    output logic signed [trb_pkg::OUT_W-1:0]       out_ay,
    output logic signed [trb_pkg::OUT_W-1:0]       out_bx,
    output logic signed [trb_pkg::OUT_W-1:0]       out_by,
    output logic signed [trb_pkg::OUT_W-1:0]       out_cx,
    output logic signed [trb_pkg::OUT_W-1:0]       out_cy,
    output logic signed [trb_pkg::OUT_W-1:0]       box_left,
    output logic signed [trb_pkg::OUT_W-1:0]       box_top,
    output logic        [trb_pkg::BOX_W-1:0]       box_width,
    output logic        [trb_pkg::BOX_W-1:0]       box_height,
    output logic                                   on_screen
);

    localparam int NS = trb_pkg::NUM_STAGES;
    localparam int NV = trb_pkg::NUM_VTX;

    // Screen size registers
    logic [trb_pkg::CFG_W-1:0] screen_w_reg, screen_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= trb_pkg::SCREEN_W_RST;
            screen_h_reg <= trb_pkg::SCREEN_H_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (trb_pkg::cfg_reg_t'(cfg_index))
                trb_pkg::REG_SCREEN_WIDTH:  screen_w_reg <= cfg_data;
                trb_pkg::REG_SCREEN_HEIGHT: screen_h_reg <= cfg_data;
            endcase
        end
    end

    // Stage valid bits and ready chain
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] rdy;
    logic [NS-1:0] load;

    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                vld_next[k] = rdy[k] ? in_valid : vld_reg[k];
                load[k]     = rdy[k] && in_valid;
            end
            else
            begin
                vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
                load[k]     = rdy[k] && vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NS-1];

    // Stage load strobes
    trb_pkg::xf_load_t  xf_ld;
    trb_pkg::box_load_t box_ld;

    assign xf_ld.s1  = load[0];
    assign xf_ld.s2  = load[1];
    assign xf_ld.s3  = load[2];
    assign xf_ld.s4  = load[3];
    assign box_ld.s5 = load[4];
    assign box_ld.s6 = load[5];

    // Vertex lanes
    logic signed [COORD_BITS-1:0]     vx [NV];
    logic signed [COORD_BITS-1:0]     vy [NV];
    logic signed [trb_pkg::OUT_W-1:0] px [NV];
    logic signed [trb_pkg::OUT_W-1:0] py [NV];
    logic signed [trb_pkg::OUT_W-1:0] qx [NV];
    logic signed [trb_pkg::OUT_W-1:0] qy [NV];

    assign vx[0] = ax;
    assign vy[0] = ay;
    assign vx[1] = bxin;
    assign vy[1] = byin;
    assign vx[2] = cx;
    assign vy[2] = cy;

    trb_xform #(
        .COORD_BITS (COORD_BITS)
    ) u_xform (
        .clk    (clk),
        .ld     (xf_ld),
        .vx     (vx),
        .vy     (vy),
        .scale  (scale_factor),
        .cos_v  (cos_rot),
        .sin_v  (sin_rot),
        .tx     (shift_x),
        .ty     (shift_y),
        .px     (px),
        .py     (py)
    );

    trb_box u_box (
        .clk      (clk),
        .ld       (box_ld),
        .px       (px),
        .py       (py),
        .screen_w (screen_w_reg),
        .screen_h (screen_h_reg),
        .qx       (qx),
        .qy       (qy),
        .left     (box_left),
        .top      (box_top),
        .width    (box_width),
        .height   (box_height),
        .all_in   (on_screen)
    );

    assign out_ax = qx[0];
    assign out_ay = qy[0];
    assign out_bx = qx[1];
    assign out_by = qy[1];
    assign out_cx = qx[2];
    assign out_cy = qy[2];

endmodule

/* sv/trb_xform.sv */
// ----------------------------------------------------------------------------
// trb_xform
// Four stage vertex transform for three vertices in parallel lanes:
// scale multiply, truncate and rotate multiply, sum and truncate,
// translate and saturate.
// ----------------------------------------------------------------------------
module trb_xform #(
    parameter int COORD_BITS = trb_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  trb_pkg::xf_load_t                     ld,
    input  logic signed [COORD_BITS-1:0]          vx  [trb_pkg::NUM_VTX],
    input  logic signed [COORD_BITS-1:0]          vy  [trb_pkg::NUM_VTX],
    input  logic        [trb_pkg::SCALE_W-1:0]    scale,
    input  logic signed [trb_pkg::TRIG_W-1:0]     cos_v,
    input  logic signed [trb_pkg::TRIG_W-1:0]     sin_v,
    input  logic signed [trb_pkg::SHIFT_W-1:0]    tx,
    input  logic signed [trb_pkg::SHIFT_W-1:0]    ty,
    output logic signed [trb_pkg::OUT_W-1:0]      px  [trb_pkg::NUM_VTX],
    output logic signed [trb_pkg::OUT_W-1:0]      py  [trb_pkg::NUM_VTX]
);

    localparam int NV     = trb_pkg::NUM_VTX;
    localparam int PROD_W = COORD_BITS + trb_pkg::SCALE_W + 1;
    localparam int SX_W   = PROD_W - trb_pkg::SCALE_FRAC;
    localparam int MUL_W  = SX_W + trb_pkg::TRIG_W;
    localparam int SUM_W  = MUL_W + 1;
    localparam int RX_W   = SUM_W - trb_pkg::TRIG_FRAC;
    localparam int TR_W   = ((RX_W > trb_pkg::SHIFT_W) ? RX_W : trb_pkg::SHIFT_W) + 1;
    localparam int EXT_W  = (TR_W > trb_pkg::OUT_W + 1) ? TR_W : trb_pkg::OUT_W + 1;

    localparam logic signed [PROD_W-1:0] SX_BIAS  = PROD_W'((1 << trb_pkg::SCALE_FRAC) - 1);
    localparam logic signed [SUM_W-1:0]  RX_BIAS  = SUM_W'((1 << trb_pkg::TRIG_FRAC) - 1);
    localparam logic signed [EXT_W-1:0]  SAT_HI   = EXT_W'((1 << (trb_pkg::OUT_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0]  SAT_LO   = EXT_W'(-(1 << (trb_pkg::OUT_W - 1)));

    // Clamp to the output range
    function automatic logic signed [trb_pkg::OUT_W-1:0] sat_coord(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] c;
        begin
            c = v;
            if (v > SAT_HI)
            begin
                c = SAT_HI;
            end
            else if (v < SAT_LO)
            begin
                c = SAT_LO;
            end
            return c[trb_pkg::OUT_W-1:0];
        end
    endfunction

    // Stage 1: scale products
    logic signed [PROD_W-1:0]          prodx_reg [NV];
    logic signed [PROD_W-1:0]          prody_reg [NV];
    logic signed [PROD_W-1:0]          prodx_next [NV];
    logic signed [PROD_W-1:0]          prody_next [NV];
    logic signed [trb_pkg::TRIG_W-1:0] cos1_reg, sin1_reg;
    logic signed [trb_pkg::SHIFT_W-1:0] tx1_reg, ty1_reg;

    // Stage 2: rotate products
    logic signed [MUL_W-1:0]           xc_reg [NV];
    logic signed [MUL_W-1:0]           xs_reg [NV];
    logic signed [MUL_W-1:0]           yc_reg [NV];
    logic signed [MUL_W-1:0]           ys_reg [NV];
    logic signed [MUL_W-1:0]           xc_next [NV];
    logic signed [MUL_W-1:0]           xs_next [NV];
    logic signed [MUL_W-1:0]           yc_next [NV];
    logic signed [MUL_W-1:0]           ys_next [NV];
    logic signed [trb_pkg::SHIFT_W-1:0] tx2_reg, ty2_reg;

    // Stage 3: rotated coordinates
    logic signed [RX_W-1:0]            rx_reg [NV];
    logic signed [RX_W-1:0]            ry_reg [NV];
    logic signed [RX_W-1:0]            rx_next [NV];
    logic signed [RX_W-1:0]            ry_next [NV];
    logic signed [trb_pkg::SHIFT_W-1:0] tx3_reg, ty3_reg;

    // Stage 4: screen coordinates
    logic signed [trb_pkg::OUT_W-1:0]  px_reg [NV];
    logic signed [trb_pkg::OUT_W-1:0]  py_reg [NV];
    logic signed [trb_pkg::OUT_W-1:0]  px_next [NV];
    logic signed [trb_pkg::OUT_W-1:0]  py_next [NV];

    // Scale multiply, exact
    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            prodx_next[i] = PROD_W'(vx[i]) * PROD_W'($signed({1'b0, scale}));
            prody_next[i] = PROD_W'(vy[i]) * PROD_W'($signed({1'b0, scale}));
        end
    end

    // Truncate scaled value toward zero, then rotate multiply
    always_comb
    begin
        logic signed [PROD_W-1:0] bx, by;
        logic signed [SX_W-1:0]   sx, sy;
        for (int i = 0; i < NV; i++)
        begin
            bx = prodx_reg[i] + (prodx_reg[i][PROD_W-1] ? SX_BIAS : '0);
            by = prody_reg[i] + (prody_reg[i][PROD_W-1] ? SX_BIAS : '0);
            sx = $signed(bx[PROD_W-1:trb_pkg::SCALE_FRAC]);
            sy = $signed(by[PROD_W-1:trb_pkg::SCALE_FRAC]);
            xc_next[i] = MUL_W'(sx) * MUL_W'(cos1_reg);
            xs_next[i] = MUL_W'(sx) * MUL_W'(sin1_reg);
            yc_next[i] = MUL_W'(sy) * MUL_W'(cos1_reg);
            ys_next[i] = MUL_W'(sy) * MUL_W'(sin1_reg);
        end
    end

    // Rotation sums, truncated toward zero
    always_comb
    begin
        logic signed [SUM_W-1:0] sumx, sumy, bx, by;
        for (int i = 0; i < NV; i++)
        begin
            sumx = SUM_W'(xc_reg[i]) - SUM_W'(ys_reg[i]);
            sumy = SUM_W'(xs_reg[i]) + SUM_W'(yc_reg[i]);
            bx   = sumx + (sumx[SUM_W-1] ? RX_BIAS : '0);
            by   = sumy + (sumy[SUM_W-1] ? RX_BIAS : '0);
            rx_next[i] = $signed(bx[SUM_W-1:trb_pkg::TRIG_FRAC]);
            ry_next[i] = $signed(by[SUM_W-1:trb_pkg::TRIG_FRAC]);
        end
    end

    // Translate and saturate
    always_comb
    begin
        logic signed [TR_W-1:0] tx_sum, ty_sum;
        for (int i = 0; i < NV; i++)
        begin
            tx_sum = TR_W'(rx_reg[i]) + TR_W'(tx3_reg);
            ty_sum = TR_W'(ry_reg[i]) + TR_W'(ty3_reg);
            px_next[i] = sat_coord(EXT_W'(tx_sum));
            py_next[i] = sat_coord(EXT_W'(ty_sum));
        end
    end

    // Pipeline registers, payload only
    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
            cos1_reg  <= cos_v;
            sin1_reg  <= sin_v;
            tx1_reg   <= tx;
            ty1_reg   <= ty;
        end
        if (ld.s2)
        begin
            xc_reg  <= xc_next;
            xs_reg  <= xs_next;
            yc_reg  <= yc_next;
            ys_reg  <= ys_next;
            tx2_reg <= tx1_reg;
            ty2_reg <= ty1_reg;
        end
        if (ld.s3)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            tx3_reg <= tx2_reg;
            ty3_reg <= ty2_reg;
        end
        if (ld.s4)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    assign px = px_reg;
    assign py = py_reg;

endmodule

/* sv/trb_box.sv */
// ----------------------------------------------------------------------------
// trb_box
// Two stage bounding box: min/max and screen test, then width and height
// into the output register.
// ----------------------------------------------------------------------------
module trb_box (
    input  logic                                clk,
    input  trb_pkg::box_load_t                  ld,
    input  logic signed [trb_pkg::OUT_W-1:0]    px [trb_pkg::NUM_VTX],
    input  logic signed [trb_pkg::OUT_W-1:0]    py [trb_pkg::NUM_VTX],
    input  logic        [trb_pkg::CFG_W-1:0]    screen_w,
    input  logic        [trb_pkg::CFG_W-1:0]    screen_h,
    output logic signed [trb_pkg::OUT_W-1:0]    qx [trb_pkg::NUM_VTX],
    output logic signed [trb_pkg::OUT_W-1:0]    qy [trb_pkg::NUM_VTX],
    output logic signed [trb_pkg::OUT_W-1:0]    left,
    output logic signed [trb_pkg::OUT_W-1:0]    top,
    output logic        [trb_pkg::BOX_W-1:0]    width,
    output logic        [trb_pkg::BOX_W-1:0]    height,
    output logic                                all_in
);

    localparam int NV = trb_pkg::NUM_VTX;
    localparam int OW = trb_pkg::OUT_W;
    localparam int BW = trb_pkg::BOX_W;

    // Stage 5 registers
    logic signed [OW-1:0] px5_reg [NV];
    logic signed [OW-1:0] py5_reg [NV];
    logic signed [OW-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [OW-1:0] minx_next, maxx_next, miny_next, maxy_next;
    logic                 in5_reg, in5_next;

    // Stage 6 registers
    logic signed [OW-1:0] qx_reg [NV];
    logic signed [OW-1:0] qy_reg [NV];
    logic signed [OW-1:0] left_reg, top_reg;
    logic        [BW-1:0] width_reg, height_reg, width_next, height_next;
    logic                 inside_reg;

    // Min/max over the three vertices and screen test
    always_comb
    begin
        logic signed [BW-1:0] wx, wy, xe, ye;
        minx_next = px[0];
        maxx_next = px[0];
        miny_next = py[0];
        maxy_next = py[0];
        in5_next  = 1'b1;
        wx = $signed({{(BW - trb_pkg::CFG_W){1'b0}}, screen_w});
        wy = $signed({{(BW - trb_pkg::CFG_W){1'b0}}, screen_h});
        for (int i = 0; i < NV; i++)
        begin
            if (px[i] < minx_next)
            begin
                minx_next = px[i];
            end
            if (px[i] > maxx_next)
            begin
                maxx_next = px[i];
            end
            if (py[i] < miny_next)
            begin
                miny_next = py[i];
            end
            if (py[i] > maxy_next)
            begin
                maxy_next = py[i];
            end
            xe = BW'(px[i]);
            ye = BW'(py[i]);
            if (px[i][OW-1] || py[i][OW-1] || (xe >= wx) || (ye >= wy))
            begin
                in5_next = 1'b0;
            end
        end
    end

    // Extent plus one; never negative, fits the box width
    always_comb
    begin
        width_next  = BW'(BW'(maxx_reg) - BW'(minx_reg) + BW'(1));
        height_next = BW'(BW'(maxy_reg) - BW'(miny_reg) + BW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (ld.s5)
        begin
            px5_reg  <= px;
            py5_reg  <= py;
            minx_reg <= minx_next;
            maxx_reg <= maxx_next;
            miny_reg <= miny_next;
            maxy_reg <= maxy_next;
            in5_reg  <= in5_next;
        end
        if (ld.s6)
        begin
            qx_reg     <= px5_reg;
            qy_reg     <= py5_reg;
            left_reg   <= minx_reg;
            top_reg    <= miny_reg;
            width_reg  <= width_next;
            height_reg <= height_next;
            inside_reg <= in5_reg;
        end
    end

    assign qx     = qx_reg;
    assign qy     = qy_reg;
    assign left   = left_reg;
    assign top    = top_reg;
    assign width  = width_reg;
    assign height = height_reg;
    assign all_in = inside_reg;

endmodule

/* sv/trb_checker.sv */
// ----------------------------------------------------------------------------
// trb_checker
// Port level checks on the result channel of the transform unit.
// ----------------------------------------------------------------------------
module trb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [trb_pkg::OUT_W-1:0]    out_ax,
    input  logic signed [trb_pkg::OUT_W-1:0]    out_bx,
    input  logic signed [trb_pkg::OUT_W-1:0]    out_cx,
    input  logic signed [trb_pkg::OUT_W-1:0]    box_left,
    input  logic signed [trb_pkg::OUT_W-1:0]    box_top,
    input  logic        [trb_pkg::BOX_W-1:0]    box_width,
    input  logic        [trb_pkg::BOX_W-1:0]    box_height,
    input  logic                                on_screen
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_ax) && $stable(box_width))
        else $error("stalled result changed");

    // Box is never empty
    a_box_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (box_width != '0) && (box_height != '0))
        else $error("empty bounding box");

    // On-screen triangle has a nonnegative corner
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && on_screen |-> !box_left[trb_pkg::OUT_W-1] && !box_top[trb_pkg::OUT_W-1])
        else $error("on-screen box with negative corner");

    // Left edge is the smallest x and one of the vertices
    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (box_left <= out_ax) && (box_left <= out_bx) && (box_left <= out_cx)
                   && ((box_left == out_ax) || (box_left == out_bx) || (box_left == out_cx)))
        else $error("box_left is not the minimum x");

endmodule

bind triangle_transform_bbox_unit trb_checker u_trb_checker (.*);

/* tb/triangle_transform_bbox_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_transform_bbox_unit_test
// Self-checking bench for the triangle transform and bounding box unit.
// Every accepted triangle is run through a local transform model (scale,
// rotate, translate, saturate, box, screen test) and the result is queued.
// Each result leaving the block is matched field by field against the
// oldest queued one. Both channels idle and stall at random, and the screen
// size is changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module triangle_transform_bbox_unit_test;

    localparam int     COORD_BITS    = trb_pkg::COORD_BITS_DEF;
    localparam int     NUM_VTX       = trb_pkg::NUM_VTX;
    localparam int     NUM_STAGES    = trb_pkg::NUM_STAGES;
    localparam int     SCALE_W       = trb_pkg::SCALE_W;
    localparam int     TRIG_W        = trb_pkg::TRIG_W;
    localparam int     SHIFT_W       = trb_pkg::SHIFT_W;
    localparam int     OUT_W         = trb_pkg::OUT_W;
    localparam int     BOX_W         = trb_pkg::BOX_W;
    localparam int     CFG_W         = trb_pkg::CFG_W;
    localparam int     CFG_IDX_W     = trb_pkg::CFG_IDX_W;
    localparam int     RESET_CYCLES  = 12;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     MAX_GAP       = 20;
    localparam int     MAX_REPORTS   = 40;
    localparam longint SCALE_ONE     = longint'(1) << trb_pkg::SCALE_FRAC;
    localparam longint TRIG_ONE      = longint'(1) << trb_pkg::TRIG_FRAC;
    localparam longint SCR_COORD_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint SCR_COORD_MIN = -(longint'(1) << (OUT_W - 1));

    // Kinds of random triangle
    typedef enum int {
        SHAPE_PLAUSIBLE,
        SHAPE_RAW,
        SHAPE_EXTREME
    } shape_kind_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic        [SCALE_W-1:0]    scale;
        logic signed [TRIG_W-1:0]     cosv;
        logic signed [TRIG_W-1:0]     sinv;
        logic signed [SHIFT_W-1:0]    tx;
        logic signed [SHIFT_W-1:0]    ty;
    } tri_req_t;

    typedef struct {
        logic signed [OUT_W-1:0] ax;
        logic signed [OUT_W-1:0] ay;
        logic signed [OUT_W-1:0] bx;
        logic signed [OUT_W-1:0] by;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] top;
        logic        [BOX_W-1:0] box_w;
        logic        [BOX_W-1:0] box_h;
        logic                    on_scr;
    } tri_screen_t;

    // DUT signals
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [CFG_W-1:0]              cfg_data     = '0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic signed [COORD_BITS-1:0]  ax           = '0;
    logic signed [COORD_BITS-1:0]  ay           = '0;
    logic signed [COORD_BITS-1:0]  bxin         = '0;
    logic signed [COORD_BITS-1:0]  byin         = '0;
    logic signed [COORD_BITS-1:0]  cx           = '0;
    logic signed [COORD_BITS-1:0]  cy           = '0;
    logic        [SCALE_W-1:0]     scale_factor = '0;
    logic signed [TRIG_W-1:0]      cos_rot      = '0;
    logic signed [TRIG_W-1:0]      sin_rot      = '0;
    logic signed [SHIFT_W-1:0]     shift_x      = '0;
    logic signed [SHIFT_W-1:0]     shift_y      = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic signed [OUT_W-1:0]       out_ax;
    logic signed [OUT_W-1:0]       out_ay;
    logic signed [OUT_W-1:0]       out_bx;
    logic signed [OUT_W-1:0]       out_by;
    logic signed [OUT_W-1:0]       out_cx;
    logic signed [OUT_W-1:0]       out_cy;
    logic signed [OUT_W-1:0]       box_left;
    logic signed [OUT_W-1:0]       box_top;
    logic        [BOX_W-1:0]       box_width;
    logic        [BOX_W-1:0]       box_height;
    logic                          on_screen;

    // Local copy of the screen registers
    logic [CFG_W-1:0] scr_width  = trb_pkg::SCREEN_W_RST;
    logic [CFG_W-1:0] scr_height = trb_pkg::SCREEN_H_RST;

    tri_screen_t predicted_tris [$];
    tri_screen_t head_tri;
    int          mismatch_count   = 0;
    int          src_idle_pct     = 35;
    int          sink_stall_pct   = 35;
    int          sink_hold_cycles = 0;
    int          quiet_cycles     = 0;

    triangle_transform_bbox_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ax           (ax),
        .ay           (ay),
        .bxin         (bxin),
        .byin         (byin),
        .cx           (cx),
        .cy           (cy),
        .scale_factor (scale_factor),
        .cos_rot      (cos_rot),
        .sin_rot      (sin_rot),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_ax       (out_ax),
        .out_ay       (out_ay),
        .out_bx       (out_bx),
        .out_by       (out_by),
        .out_cx       (out_cx),
        .out_cy       (out_cy),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_width    (box_width),
        .box_height   (box_height),
        .on_screen    (on_screen)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Transform model
    // ------------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > SCR_COORD_MAX)
            return SCR_COORD_MAX;
        if (v < SCR_COORD_MIN)
            return SCR_COORD_MIN;
        return v;
    endfunction

    function automatic tri_screen_t transform_triangle(input tri_req_t r);
        longint      vx [NUM_VTX];
        longint      vy [NUM_VTX];
        longint      px [NUM_VTX];
        longint      py [NUM_VTX];
        longint      s;
        longint      c;
        longint      sn;
        longint      tx;
        longint      ty;
        longint      sx;
        longint      sy;
        longint      lo_x;
        longint      hi_x;
        longint      lo_y;
        longint      hi_y;
        bit          all_in;
        int          i;
        tri_screen_t e;

        vx[0] = longint'(r.ax);
        vy[0] = longint'(r.ay);
        vx[1] = longint'(r.bx);
        vy[1] = longint'(r.by);
        vx[2] = longint'(r.cx);
        vy[2] = longint'(r.cy);
        s  = longint'(r.scale);
        c  = longint'(r.cosv);
        sn = longint'(r.sinv);
        tx = longint'(r.tx);
        ty = longint'(r.ty);
        all_in = 1'b1;

        // scale, rotate, translate; every division truncates toward zero
        for (i = 0; i < NUM_VTX; i++)
        begin
            sx = (vx[i] * s) / SCALE_ONE;
            sy = (vy[i] * s) / SCALE_ONE;
            px[i] = clamp_coord((sx * c - sy * sn) / TRIG_ONE + tx);
            py[i] = clamp_coord((sx * sn + sy * c) / TRIG_ONE + ty);
        end

        // box on saturated coordinates, screen test
        lo_x = px[0];
        hi_x = px[0];
        lo_y = py[0];
        hi_y = py[0];
        for (i = 0; i < NUM_VTX; i++)
        begin
            if (px[i] < lo_x) lo_x = px[i];
            if (px[i] > hi_x) hi_x = px[i];
            if (py[i] < lo_y) lo_y = py[i];
            if (py[i] > hi_y) hi_y = py[i];
            if (px[i] < 0 || px[i] >= longint'(scr_width) ||
                py[i] < 0 || py[i] >= longint'(scr_height))
                all_in = 1'b0;
        end

        e.ax     = OUT_W'(px[0]);
        e.ay     = OUT_W'(py[0]);
        e.bx     = OUT_W'(px[1]);
        e.by     = OUT_W'(py[1]);
        e.cx     = OUT_W'(px[2]);
        e.cy     = OUT_W'(py[2]);
        e.left   = OUT_W'(lo_x);
        e.top    = OUT_W'(lo_y);
        e.box_w  = BOX_W'(hi_x - lo_x + 1);
        e.box_h  = BOX_W'(hi_y - lo_y + 1);
        e.on_scr = all_in;
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // Triangle builders
    // ------------------------------------------------------------------------
    function automatic tri_req_t make_triangle(input int x0, input int y0,
                                               input int x1, input int y1,
                                               input int x2, input int y2,
                                               input int s, input int c,
                                               input int sn, input int tx,
                                               input int ty);
        tri_req_t r;
        r.ax    = COORD_BITS'(x0);
        r.ay    = COORD_BITS'(y0);
        r.bx    = COORD_BITS'(x1);
        r.by    = COORD_BITS'(y1);
        r.cx    = COORD_BITS'(x2);
        r.cy    = COORD_BITS'(y2);
        r.scale = SCALE_W'(s);
        r.cosv  = TRIG_W'(c);
        r.sinv  = TRIG_W'(sn);
        r.tx    = SHIFT_W'(tx);
        r.ty    = SHIFT_W'(ty);
        return r;
    endfunction

    function automatic int pick_edge_coord();
        case ($urandom_range(3))
            0:       return -2048;
            1:       return 2047;
            2:       return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int pick_edge_trig();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return 16384;
            3:       return -16384;
            4:       return 1;
            default: return 0;
        endcase
    endfunction

    function automatic tri_req_t random_triangle();
        shape_kind_t kind;
        tri_req_t    r;
        int          roll;
        int          lim_x;
        int          lim_y;
        real         ang;

        roll = $urandom_range(99);
        if (roll < 50)
            kind = SHAPE_PLAUSIBLE;
        else if (roll < 80)
            kind = SHAPE_RAW;
        else
            kind = SHAPE_EXTREME;

        case (kind)
            // small triangle, unit trig pair, shifted into the screen
            SHAPE_PLAUSIBLE:
            begin
                lim_x = (scr_width > 4095) ? 4095 : int'(scr_width);
                lim_y = (scr_height > 4095) ? 4095 : int'(scr_height);
                ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                r.ax    = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
                r.ay    = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
                r.bx    = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
                r.by    = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
                r.cx    = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
                r.cy    = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
                r.scale = ($urandom_range(99) < 8) ? '0 : SCALE_W'($urandom_range(16, 640));
                r.cosv  = TRIG_W'(int'($cos(ang) * 16384.0));
                r.sinv  = TRIG_W'(int'($sin(ang) * 16384.0));
                r.tx    = SHIFT_W'($urandom_range(0, lim_x));
                r.ty    = SHIFT_W'($urandom_range(0, lim_y));
            end
            SHAPE_RAW:
            begin
                r.ax    = COORD_BITS'($urandom);
                r.ay    = COORD_BITS'($urandom);
                r.bx    = COORD_BITS'($urandom);
                r.by    = COORD_BITS'($urandom);
                r.cx    = COORD_BITS'($urandom);
                r.cy    = COORD_BITS'($urandom);
                r.scale = SCALE_W'($urandom);
                r.cosv  = TRIG_W'($urandom);
                r.sinv  = TRIG_W'($urandom);
                r.tx    = SHIFT_W'($urandom);
                r.ty    = SHIFT_W'($urandom);
            end
            default:
            begin
                r.ax    = COORD_BITS'(pick_edge_coord());
                r.ay    = COORD_BITS'(pick_edge_coord());
                r.bx    = COORD_BITS'(pick_edge_coord());
                r.by    = COORD_BITS'(pick_edge_coord());
                r.cx    = COORD_BITS'(pick_edge_coord());
                r.cy    = COORD_BITS'(pick_edge_coord());
                case ($urandom_range(4))
                    0:       r.scale = '0;
                    1:       r.scale = SCALE_W'(1);
                    2:       r.scale = SCALE_W'(255);
                    3:       r.scale = SCALE_W'(256);
                    default: r.scale = 16'hFFFF;
                endcase
                r.cosv  = TRIG_W'(pick_edge_trig());
                r.sinv  = TRIG_W'(pick_edge_trig());
                r.tx    = SHIFT_W'(($urandom_range(1)) ? -4096 : 4095);
                r.ty    = SHIFT_W'(($urandom_range(2) == 0) ? 0 :
                                   (($urandom_range(1)) ? -4096 : 4095));
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_triangle(input tri_req_t r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        ax           <= r.ax;
        ay           <= r.ay;
        bxin         <= r.bx;
        byin         <= r.by;
        cx           <= r.cx;
        cy           <= r.cy;
        scale_factor <= r.scale;
        cos_rot      <= r.cosv;
        sin_rot      <= r.sinv;
        shift_x      <= r.tx;
        shift_y      <= r.ty;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_tris.push_back(transform_triangle(r));
    endtask

    // stop offering and let the pipeline run dry
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (predicted_tris.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    // both screen registers in back to back cycles; pipeline must be empty
    task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= trb_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        scr_width = w;
        cfg_index <= trb_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        scr_height = h;
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, long hold on request, compare
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_tris.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with nothing pending, expected none, got box %0d %0d",
                                 $time, box_left, box_top);
                end
                else
                begin
                    head_tri = predicted_tris.pop_front();
                    compare_field("out_ax", 32'(head_tri.ax), 32'(out_ax));
                    compare_field("out_ay", 32'(head_tri.ay), 32'(out_ay));
                    compare_field("out_bx", 32'(head_tri.bx), 32'(out_bx));
                    compare_field("out_by", 32'(head_tri.by), 32'(out_by));
                    compare_field("out_cx", 32'(head_tri.cx), 32'(out_cx));
                    compare_field("out_cy", 32'(head_tri.cy), 32'(out_cy));
                    compare_field("box_left", 32'(head_tri.left), 32'(box_left));
                    compare_field("box_top", 32'(head_tri.top), 32'(box_top));
                    compare_field("box_width", 32'(head_tri.box_w), 32'(box_width));
                    compare_field("box_height", 32'(head_tri.box_h), 32'(box_height));
                    compare_field("on_screen", 32'(head_tri.on_scr), 32'(on_screen));
                end
            end
            if (sink_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                sink_hold_cycles = sink_hold_cycles - 1;
            end
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Watchdog: too long with nothing accepted on either channel
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("triangle_transform_bbox_unit_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // corner cases under the reset screen of 640 x 480
    task automatic test_directed();
        // identity, corners just inside
        send_triangle(make_triangle(0, 0, 639, 479, 1, 1, 256, 16384, 0, 0, 0));
        // x one past the right edge, y one past the bottom, x negative
        send_triangle(make_triangle(640, 0, 0, 0, 5, 5, 256, 16384, 0, 0, 0));
        send_triangle(make_triangle(0, 480, 0, 0, 5, 5, 256, 16384, 0, 0, 0));
        send_triangle(make_triangle(-1, 0, 10, 10, 5, 5, 256, 16384, 0, 0, 0));
        // quarter turn about the origin, then centered
        send_triangle(make_triangle(100, 0, 0, 100, -50, -50, 256, 0, 16384, 320, 240));
        // zero scale collapses all vertices onto the shift
        send_triangle(make_triangle(2047, -2048, 123, -77, -2048, 2047, 0, 16384, 0, 4095, -4096));
        send_triangle(make_triangle(-300, 200, 7, 9, 1000, -1000, 0, -32768, 32767, 639, 479));
        // unnormalized trig pushes past the output range in both directions
        send_triangle(make_triangle(2047, 2047, 2047, 2047, 2047, 2047,
                                    65535, -32768, 32767, 4095, 4095));
        send_triangle(make_triangle(-2048, -2048, -2048, -2048, -2048, -2048,
                                    65535, -32768, -32768, -4096, -4096));
        send_triangle(make_triangle(2047, -2048, -2048, 2047, 0, 0,
                                    65535, 32767, -32768, 0, 0));
        send_triangle(make_triangle(-2048, 2047, 2047, -2048, -1, 1,
                                    65535, 32767, 32767, 4095, -4096));
        // truncation toward zero in the scale step
        send_triangle(make_triangle(-1, -1, 1, 1, -3, 5, 1, 16384, 0, 0, 0));
        send_triangle(make_triangle(-255, 255, -257, 257, -511, 511, 1, 16384, 0, 10, 10));
        // truncation toward zero in the rotate step
        send_triangle(make_triangle(1, -1, -1, 1, 3, -7, 256, 1, -1, 0, 0));
        send_triangle(make_triangle(-1000, 999, 37, -41, 5, 6, 256, 3, 5, 100, 100));
        // half turn, raw diagonal pair, odd scale
        send_triangle(make_triangle(10, 20, 30, 40, -5, -6, 256, -16384, 0, 100, 100));
        send_triangle(make_triangle(10, 20, 30, 40, -5, -6, 256, 16384, 16384, 100, 100));
        send_triangle(make_triangle(-2048, 2047, 100, -100, 1, 0, 255, -16384, -16384, 0, 0));
        // translation extremes
        send_triangle(make_triangle(0, 0, 1, 1, 2, 2, 256, 16384, 0, -4096, 4095));
        send_triangle(make_triangle(0, 0, 1, 1, 2, 2, 256, 16384, 0, 4095, -4096));
        wait_all_results();
    endtask

    task automatic test_random_default();
        repeat (250) send_triangle(random_triangle());
        wait_all_results();
    endtask

    // screen sizes at the ends of the register range, plus one and 4096
    task automatic test_screen_extremes();
        logic [CFG_W-1:0] widths  [6];
        logic [CFG_W-1:0] heights [6];
        int               k;
        widths  = '{13'd1, 13'd0, 13'd4096, 13'h1FFF, 13'd1, 13'd4096};
        heights = '{13'd1, 13'd0, 13'd4096, 13'h1FFF, 13'd4096, 13'd1};
        for (k = 0; k < 6; k++)
        begin
            set_screen(widths[k], heights[k]);
            repeat (80) send_triangle(random_triangle());
            wait_all_results();
        end
    endtask

    // full rate on both sides
    task automatic test_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_screen(13'd1920, 13'd1080);
        repeat (200) send_triangle(random_triangle());
        wait_all_results();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
    endtask

    // receiver holds off long enough for the pipeline to fill and stall
    task automatic test_backpressure();
        src_idle_pct     = 0;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (60) send_triangle(random_triangle());
        wait_all_results();
        src_idle_pct = 35;
    endtask

    task automatic test_random_screens();
        repeat (6)
        begin
            set_screen(CFG_W'($urandom_range(1, 4096)), CFG_W'($urandom_range(1, 4096)));
            repeat (90) send_triangle(random_triangle());
            wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_default();
        test_screen_extremes();
        test_no_idle();
        test_backpressure();
        test_random_screens();

        wait_all_results();
        repeat (NUM_STAGES * 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("triangle_transform_bbox_unit_test OK");
        else
            $display("triangle_transform_bbox_unit_test NOT OK");
        $finish;
    end

endmodule
